>>> rtl/zbh_pkg.sv
// ----------------------------------------------------------------------------
// zbh_pkg: shared constants and types for the Zobrist board hash
// Field widths, generator constants, stream packing and stage flag types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package zbh_pkg;

	// default sizing of the key tables
	localparam int PIECE_KINDS_DEF    = 7;
	localparam int SQUARE_COUNT_DEF   = 64;
	localparam int MOVE_KEY_COUNT_DEF = 200;

	// field widths
	localparam int SEED_W = 48;
	localparam int KEY_W  = 32;
	localparam int SQ_W   = 6;
	localparam int KIND_W = 3;
	localparam int FRZ_W  = 7;
	localparam int MOVE_W = 16;

	// stream packing
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 40;

	// 48-bit linear congruential generator, multiplier split at bit 24
	localparam logic [SEED_W-1:0] LCG_MULT   = 48'h0005_DEEC_E66D;
	localparam logic [SEED_W-1:0] LCG_ADD    = 48'h0000_0000_000B;
	localparam logic [SEED_W-1:0] SEED_RESET = 48'd43;
	localparam logic [23:0]       MULT_LO    = 24'hECE66D;
	localparam logic [23:0]       MULT_HI    = 24'h0005DE;

	typedef enum logic [1:0] {
		GEN_MUL,
		GEN_ADD,
		GEN_DONE
	} gen_state_t;

	// per-item flags that travel with the key reads
	typedef struct packed {
		logic last;
		logic black_to_move;
		logic piece_hit;
		logic frz_w_hit;
		logic frz_b_hit;
	} stage_flags_t;

endpackage

`default_nettype wire

>>> rtl/zbh_keygen.sv
// ----------------------------------------------------------------------------
// zbh_keygen: key generator and table fill sequencer
// Steps the 48-bit generator through a multiply state and an add state per key and writes every key once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zbh_keygen #(
	parameter int STORE_SIZE = 1225,
	parameter int IDX_W      = 11
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	input  wire logic [zbh_pkg::SEED_W-1:0] cfg_data,
	input  wire logic                       item_acc,
	output logic                            fill_we,
	output logic [IDX_W-1:0]                fill_idx,
	output logic [zbh_pkg::KEY_W-1:0]       fill_key,
	output logic                            keys_ready
);

	zbh_pkg::gen_state_t state_q, state_d;

	logic [zbh_pkg::SEED_W-1:0] gen_q;
	logic [zbh_pkg::SEED_W-1:0] prod_lo_q;
	logic [23:0]                cross_a_q;
	logic [23:0]                cross_b_q;
	logic [zbh_pkg::SEED_W-1:0] gen_next;
	logic [IDX_W-1:0]           idx_q;
	logic                       locked_q;
	logic                       restart;

	// a seed write before the first item reruns the fill with the new seed
	assign restart = cfg_valid && !locked_q;

	assign gen_next = prod_lo_q + {cross_a_q + cross_b_q, 24'd0} + zbh_pkg::LCG_ADD;

	always_comb begin
		state_d = state_q;
		fill_we = 1'b0;
		case (state_q)
			zbh_pkg::GEN_MUL: begin
				state_d = zbh_pkg::GEN_ADD;
			end
			zbh_pkg::GEN_ADD: begin
				fill_we = 1'b1;
				state_d = (idx_q == IDX_W'(STORE_SIZE - 1)) ? zbh_pkg::GEN_DONE
					: zbh_pkg::GEN_MUL;
			end
			zbh_pkg::GEN_DONE: begin
				state_d = zbh_pkg::GEN_DONE;
			end
			default: begin
				state_d = zbh_pkg::GEN_MUL;
			end
		endcase
		if (restart) begin
			state_d = zbh_pkg::GEN_MUL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= zbh_pkg::GEN_MUL;
			gen_q    <= zbh_pkg::SEED_RESET ^ zbh_pkg::LCG_MULT;
			idx_q    <= '0;
			locked_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			locked_q <= locked_q || item_acc;
			if (restart) begin
				gen_q <= cfg_data ^ zbh_pkg::LCG_MULT;
				idx_q <= '0;
			end else if (state_q == zbh_pkg::GEN_ADD) begin
				gen_q <= gen_next;
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// partial products of state times multiplier, modulo 2^48
	always_ff @(posedge clk) begin
		if (state_q == zbh_pkg::GEN_MUL) begin
			prod_lo_q <= 48'(gen_q[23:0]) * 48'(zbh_pkg::MULT_LO);
			cross_a_q <= gen_q[47:24] * zbh_pkg::MULT_LO;
			cross_b_q <= gen_q[23:0] * zbh_pkg::MULT_HI;
		end
	end

	assign fill_idx   = idx_q;
	assign fill_key   = gen_next[47:16];
	assign keys_ready = (state_q == zbh_pkg::GEN_DONE);

endmodule

`default_nettype wire

>>> rtl/zbh_keystore.sv
// ----------------------------------------------------------------------------
// zbh_keystore: key memories
// Piece, frozen-square and move-number key memories plus the side key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zbh_keystore #(
	parameter int PIECE_KINDS    = 7,
	parameter int SQUARE_COUNT   = 64,
	parameter int MOVE_KEY_COUNT = 200,
	parameter int IDX_W          = 11,
	parameter int PAW            = 10,
	parameter int FAW            = 7,
	parameter int MAW            = 8
) (
	input  wire logic                       clk,
	input  wire logic                       fill_we,
	input  wire logic [IDX_W-1:0]           fill_idx,
	input  wire logic [zbh_pkg::KEY_W-1:0]  fill_key,
	input  wire logic                       rd_en,
	input  wire logic [PAW-1:0]             piece_addr,
	input  wire logic [FAW-1:0]             frz_w_addr,
	input  wire logic [FAW-1:0]             frz_b_addr,
	input  wire logic [MAW-1:0]             move_addr,
	output logic      [zbh_pkg::KEY_W-1:0]  piece_key_s3,
	output logic      [zbh_pkg::KEY_W-1:0]  frz_w_key_s3,
	output logic      [zbh_pkg::KEY_W-1:0]  frz_b_key_s3,
	output logic      [zbh_pkg::KEY_W-1:0]  move_key_s3,
	output logic      [zbh_pkg::KEY_W-1:0]  side_key
);

	localparam int PIECE_DEPTH = PIECE_KINDS * SQUARE_COUNT * 2;
	localparam int FRZ_DEPTH   = 2 * SQUARE_COUNT;
	localparam int FROZEN_BASE = PIECE_DEPTH;
	localparam int MOVE_BASE   = FROZEN_BASE + FRZ_DEPTH;
	localparam int SIDE_INDEX  = MOVE_BASE + MOVE_KEY_COUNT;

	logic [zbh_pkg::KEY_W-1:0] piece_mem  [PIECE_DEPTH];
	logic [zbh_pkg::KEY_W-1:0] frozen_mem [FRZ_DEPTH];
	logic [zbh_pkg::KEY_W-1:0] move_mem   [MOVE_KEY_COUNT];
	logic [zbh_pkg::KEY_W-1:0] side_key_q;

	// fill writes go to the memory whose range holds the index
	always_ff @(posedge clk) begin
		if (fill_we) begin
			if (fill_idx < IDX_W'(FROZEN_BASE)) begin
				piece_mem[PAW'(fill_idx)] <= fill_key;
			end else if (fill_idx < IDX_W'(MOVE_BASE)) begin
				frozen_mem[FAW'(fill_idx - IDX_W'(FROZEN_BASE))] <= fill_key;
			end else if (fill_idx < IDX_W'(SIDE_INDEX)) begin
				move_mem[MAW'(fill_idx - IDX_W'(MOVE_BASE))] <= fill_key;
			end else begin
				side_key_q <= fill_key;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			piece_key_s3 <= piece_mem[piece_addr];
			frz_w_key_s3 <= frozen_mem[frz_w_addr];
			frz_b_key_s3 <= frozen_mem[frz_b_addr];
			move_key_s3  <= move_mem[move_addr];
		end
	end

	assign side_key = side_key_q;

endmodule

`default_nettype wire

>>> rtl/zbh_front.sv
// ----------------------------------------------------------------------------
// zbh_front: input register and address stage
// Registers a beat, forms key addresses and reduces the move number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zbh_front #(
	parameter int PIECE_KINDS    = 7,
	parameter int SQUARE_COUNT   = 64,
	parameter int MOVE_KEY_COUNT = 200,
	parameter int PAW            = 10,
	parameter int FAW            = 7,
	parameter int MAW            = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_acc,
	input  wire logic [zbh_pkg::SQ_W-1:0]    square,
	input  wire logic                        occupied,
	input  wire logic [zbh_pkg::KIND_W-1:0]  piece_type,
	input  wire logic                        piece_black,
	input  wire logic                        last,
	input  wire logic                        black_to_move,
	input  wire logic signed [zbh_pkg::FRZ_W-1:0] frozen_white_square,
	input  wire logic signed [zbh_pkg::FRZ_W-1:0] frozen_black_square,
	input  wire logic [zbh_pkg::MOVE_W-1:0]  move_count,
	input  wire logic [zbh_pkg::KEY_W-1:0]   stored_hash,
	input  wire logic                        en3,
	output logic                             en1,
	output logic                             valid_s2,
	output zbh_pkg::stage_flags_t            flags_s2,
	output logic [zbh_pkg::KEY_W-1:0]        cached_s2,
	output logic [PAW-1:0]                   piece_addr_s2,
	output logic [FAW-1:0]                   frz_w_addr_s2,
	output logic [FAW-1:0]                   frz_b_addr_s2,
	output logic [MAW-1:0]                   move_addr
);

	// ceiling reciprocal, exact quotient for any 16-bit move number
	localparam logic [32:0] MOVE_RECIP =
		33'(((64'd1 << 32) + 64'(MOVE_KEY_COUNT) - 64'd1) / 64'(MOVE_KEY_COUNT));
	localparam logic [zbh_pkg::MOVE_W-1:0] MOVE_MOD = zbh_pkg::MOVE_W'(MOVE_KEY_COUNT);

	logic                           valid_s1;
	logic [zbh_pkg::SQ_W-1:0]       sq_s1;
	logic                           occ_s1;
	logic [zbh_pkg::KIND_W-1:0]     kind_s1;
	logic                           black_s1;
	logic                           last_s1;
	logic                           btm_s1;
	logic [zbh_pkg::FRZ_W-1:0]      fw_s1;
	logic [zbh_pkg::FRZ_W-1:0]      fb_s1;
	logic [zbh_pkg::MOVE_W-1:0]     mn_s1;
	logic [zbh_pkg::KEY_W-1:0]      cached_s1;

	logic [zbh_pkg::MOVE_W-1:0]     mn_s2;
	logic [zbh_pkg::MOVE_W-1:0]     quot_s2;

	logic                           en2;
	zbh_pkg::stage_flags_t          flags_d;
	logic [48:0]                    recip_prod;
	logic [zbh_pkg::MOVE_W-1:0]     rem;

	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= in_acc;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sq_s1     <= square;
			occ_s1    <= occupied;
			kind_s1   <= piece_type;
			black_s1  <= piece_black;
			last_s1   <= last;
			btm_s1    <= black_to_move;
			fw_s1     <= frozen_white_square;
			fb_s1     <= frozen_black_square;
			mn_s1     <= move_count;
			cached_s1 <= stored_hash;
		end
	end

	// hits drop the key for an out-of-range kind or square
	always_comb begin
		flags_d.last          = last_s1;
		flags_d.black_to_move = btm_s1;
		flags_d.piece_hit     = occ_s1 && (32'(kind_s1) < PIECE_KINDS)
			&& (32'(sq_s1) < SQUARE_COUNT);
		flags_d.frz_w_hit     = !fw_s1[6] && (32'(fw_s1[5:0]) < SQUARE_COUNT);
		flags_d.frz_b_hit     = !fb_s1[6] && (32'(fb_s1[5:0]) < SQUARE_COUNT);
	end

	assign recip_prod = 49'(mn_s1) * 49'(MOVE_RECIP);

	always_ff @(posedge clk) begin
		if (en2) begin
			flags_s2      <= flags_d;
			cached_s2     <= cached_s1;
			piece_addr_s2 <= PAW'({32'(kind_s1) * 32'(SQUARE_COUNT) + 32'(sq_s1), black_s1});
			frz_w_addr_s2 <= FAW'({fw_s1[5:0], 1'b0});
			frz_b_addr_s2 <= FAW'({fb_s1[5:0], 1'b1});
			mn_s2         <= mn_s1;
			quot_s2       <= recip_prod[47:32];
		end
	end

	// remainder, with one correction step held in reserve
	assign rem = mn_s2 - zbh_pkg::MOVE_W'(quot_s2 * MOVE_MOD);
	assign move_addr = (rem >= MOVE_MOD) ? MAW'(rem - MOVE_MOD) : MAW'(rem);

endmodule

`default_nettype wire

>>> rtl/zbh_fold.sv
// ----------------------------------------------------------------------------
// zbh_fold: hash accumulator and result register
// Folds the read keys into the running hash and presents finished boards.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zbh_fold (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       valid_s2,
	input  wire zbh_pkg::stage_flags_t      flags_s2,
	input  wire logic [zbh_pkg::KEY_W-1:0]  cached_s2,
	input  wire logic [zbh_pkg::KEY_W-1:0]  piece_key_s3,
	input  wire logic [zbh_pkg::KEY_W-1:0]  frz_w_key_s3,
	input  wire logic [zbh_pkg::KEY_W-1:0]  frz_b_key_s3,
	input  wire logic [zbh_pkg::KEY_W-1:0]  move_key_s3,
	input  wire logic [zbh_pkg::KEY_W-1:0]  side_key,
	input  wire logic                       out_ready,
	output logic                            en3,
	output logic                            out_valid,
	output logic [zbh_pkg::KEY_W-1:0]       hash,
	output logic                            matches_cached
);

	logic                      valid_s3;
	zbh_pkg::stage_flags_t     flags_s3;
	logic [zbh_pkg::KEY_W-1:0] cached_s3;
	logic [zbh_pkg::KEY_W-1:0] run_q;
	logic [zbh_pkg::KEY_W-1:0] run_next;
	logic [zbh_pkg::KEY_W-1:0] final_hash;
	logic                      out_free;
	logic                      retire;

	// only a last beat needs the result register
	assign out_free = !out_valid || out_ready;
	assign retire   = valid_s3 && (!flags_s3.last || out_free);
	assign en3      = !valid_s3 || retire;

	assign run_next = run_q ^ (flags_s3.piece_hit ? piece_key_s3 : '0);

	assign final_hash = run_next
		^ (flags_s3.black_to_move ? side_key : '0)
		^ (flags_s3.frz_w_hit ? frz_w_key_s3 : '0)
		^ (flags_s3.frz_b_hit ? frz_b_key_s3 : '0)
		^ move_key_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
			run_q     <= '0;
		end else begin
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (retire) begin
				run_q <= flags_s3.last ? '0 : run_next;
			end
			if (retire && flags_s3.last) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			flags_s3  <= flags_s2;
			cached_s3 <= cached_s2;
		end
		if (retire && flags_s3.last) begin
			hash           <= final_hash;
			matches_cached <= (final_hash == cached_s3);
		end
	end

endmodule

`default_nettype wire

>>> rtl/zobrist_board_hash.sv
// ----------------------------------------------------------------------------
// zobrist_board_hash: 32-bit Zobrist hash over a stream of square beats
// Throughput one beat per cycle when no stage is blocked; a last beat passes s1, s2 and s3 to its result.
// After reset the key fill writes all 1225 keys while ready is low.
// Reset is asynchronous, active low; a seed write before the first beat refills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Stage layout:
//   s1  input register holding the accepted beat
//   s2  key addresses, move-number quotient by reciprocal multiply
//   s3  key memory read data, remainder already resolved into the move address
//   out result register; the accumulator folds at the s3 to out step
// The s1 -> s2 -> s3 chain stalls only where a stage is full and the next is
// blocked, so square beats keep flowing while a finished hash waits.
// The key fill runs each generator step through a multiply state and an add state:
// the 48 x 35 bit multiply is cut into three partial products registered before the sum.

module zobrist_board_hash #(
	parameter int PIECE_KINDS    = zbh_pkg::PIECE_KINDS_DEF,
	parameter int SQUARE_COUNT   = zbh_pkg::SQUARE_COUNT_DEF,
	parameter int MOVE_KEY_COUNT = zbh_pkg::MOVE_KEY_COUNT_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// square beat
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// tdata from bit 0: square[6], occupied, piece_type[3], piece_black,
	// black_to_move, frozen_white_square[7], frozen_black_square[7],
	// move_count[16], stored_hash[32], zero fill to 80 bits
	input  wire logic [zbh_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  wire logic                               s_tlast,
	// seed register
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [zbh_pkg::SEED_W-1:0]         cfg_data,
	// result beat
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// tdata from bit 0: hash[32], matches_cached, zero fill to 40 bits
	output logic [zbh_pkg::OUT_TDATA_W-1:0]         m_tdata
);

	localparam int PIECE_DEPTH = PIECE_KINDS * SQUARE_COUNT * 2;
	localparam int STORE_SIZE  = PIECE_DEPTH + 2 * SQUARE_COUNT + MOVE_KEY_COUNT + 1;
	localparam int IDX_W       = $clog2(STORE_SIZE);
	localparam int PAW         = $clog2(PIECE_DEPTH);
	localparam int FAW         = $clog2(2 * SQUARE_COUNT);
	localparam int MAW         = (MOVE_KEY_COUNT > 1) ? $clog2(MOVE_KEY_COUNT) : 1;

	logic                      keys_ready;
	logic                      in_acc;
	logic                      en1;
	logic                      en3;
	logic                      fill_we;
	logic [IDX_W-1:0]          fill_idx;
	logic [zbh_pkg::KEY_W-1:0] fill_key;

	logic                      valid_s2;
	zbh_pkg::stage_flags_t     flags_s2;
	logic [zbh_pkg::KEY_W-1:0] cached_s2;
	logic [PAW-1:0]            piece_addr_s2;
	logic [FAW-1:0]            frz_w_addr_s2;
	logic [FAW-1:0]            frz_b_addr_s2;
	logic [MAW-1:0]            move_addr;

	logic [zbh_pkg::KEY_W-1:0] piece_key_s3;
	logic [zbh_pkg::KEY_W-1:0] frz_w_key_s3;
	logic [zbh_pkg::KEY_W-1:0] frz_b_key_s3;
	logic [zbh_pkg::KEY_W-1:0] move_key_s3;
	logic [zbh_pkg::KEY_W-1:0] side_key;

	logic [zbh_pkg::KEY_W-1:0] hash;
	logic                      matches_cached;

	// hold off square beats until every key is in place
	assign s_tready  = keys_ready && en1;
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	zbh_keygen #(
		.STORE_SIZE (STORE_SIZE),
		.IDX_W      (IDX_W)
	) u_keygen (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.item_acc   (in_acc),
		.fill_we    (fill_we),
		.fill_idx   (fill_idx),
		.fill_key   (fill_key),
		.keys_ready (keys_ready)
	);

	// unpack the beat fields from tdata
	zbh_front #(
		.PIECE_KINDS    (PIECE_KINDS),
		.SQUARE_COUNT   (SQUARE_COUNT),
		.MOVE_KEY_COUNT (MOVE_KEY_COUNT),
		.PAW            (PAW),
		.FAW            (FAW),
		.MAW            (MAW)
	) u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_acc              (in_acc),
		.square              (s_tdata[5:0]),
		.occupied            (s_tdata[6]),
		.piece_type          (s_tdata[9:7]),
		.piece_black         (s_tdata[10]),
		.last                (s_tlast),
		.black_to_move       (s_tdata[11]),
		.frozen_white_square (s_tdata[18:12]),
		.frozen_black_square (s_tdata[25:19]),
		.move_count          (s_tdata[41:26]),
		.stored_hash         (s_tdata[73:42]),
		.en3                 (en3),
		.en1                 (en1),
		.valid_s2            (valid_s2),
		.flags_s2            (flags_s2),
		.cached_s2           (cached_s2),
		.piece_addr_s2       (piece_addr_s2),
		.frz_w_addr_s2       (frz_w_addr_s2),
		.frz_b_addr_s2       (frz_b_addr_s2),
		.move_addr           (move_addr)
	);

	// key reads advance together with the s3 stage
	zbh_keystore #(
		.PIECE_KINDS    (PIECE_KINDS),
		.SQUARE_COUNT   (SQUARE_COUNT),
		.MOVE_KEY_COUNT (MOVE_KEY_COUNT),
		.IDX_W          (IDX_W),
		.PAW            (PAW),
		.FAW            (FAW),
		.MAW            (MAW)
	) u_keystore (
		.clk          (clk),
		.fill_we      (fill_we),
		.fill_idx     (fill_idx),
		.fill_key     (fill_key),
		.rd_en        (en3),
		.piece_addr   (piece_addr_s2),
		.frz_w_addr   (frz_w_addr_s2),
		.frz_b_addr   (frz_b_addr_s2),
		.move_addr    (move_addr),
		.piece_key_s3 (piece_key_s3),
		.frz_w_key_s3 (frz_w_key_s3),
		.frz_b_key_s3 (frz_b_key_s3),
		.move_key_s3  (move_key_s3),
		.side_key     (side_key)
	);

	zbh_fold u_fold (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s2       (valid_s2),
		.flags_s2       (flags_s2),
		.cached_s2      (cached_s2),
		.piece_key_s3   (piece_key_s3),
		.frz_w_key_s3   (frz_w_key_s3),
		.frz_b_key_s3   (frz_b_key_s3),
		.move_key_s3    (move_key_s3),
		.side_key       (side_key),
		.out_ready      (m_tready),
		.en3            (en3),
		.out_valid      (m_tvalid),
		.hash           (hash),
		.matches_cached (matches_cached)
	);

	// pack the result beat, zero fill above the flag
	assign m_tdata = {7'd0, matches_cached, hash};

endmodule

`default_nettype wire

>>> rtl/zbh_checker.sv
// ----------------------------------------------------------------------------
// zbh_checker: port-level checks for the Zobrist board hash
// Watches reset, seed writes and result beats on the top level's ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zbh_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_tvalid,
	input wire logic                               s_tready,
	input wire logic                               cfg_valid,
	input wire logic                               cfg_ready,
	input wire logic                               m_tvalid,
	input wire logic                               m_tready,
	input wire logic [zbh_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	logic seen_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_item_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			seen_item_q <= 1'b1;
		end
	end

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// the key fill keeps the input closed straight after reset
	a_fill_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !s_tready)
		else $error("input ready before key fill");

	// a seed write before the first beat restarts the fill
	a_seed_refill: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && !seen_item_q |=> !s_tready)
		else $error("seed write did not restart key fill");

	// no result without an accepted beat
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> seen_item_q)
		else $error("result beat before any input beat");

endmodule

bind zobrist_board_hash zbh_checker u_zbh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);

`default_nettype wire

>>> bench/board_hash_checker.sv
// ----------------------------------------------------------------------------
// board_hash_checker: scoreboard for the Zobrist board hash
// Watches the seed, square and result channels, rebuilds the key table and
// the running hash, and compares every result beat with the oldest board.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module board_hash_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	input  wire logic                               s_tready,
	// from bit 0: square, occupied, piece_type, piece_black, black_to_move,
	// frozen_white_square, frozen_black_square, move_count, stored_hash
	input  wire logic [zbh_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  wire logic                               s_tlast,
	input  wire logic                               cfg_valid,
	input  wire logic                               cfg_ready,
	input  wire logic [zbh_pkg::SEED_W-1:0]         cfg_data,
	input  wire logic                               m_tvalid,
	input  wire logic                               m_tready,
	// from bit 0: hash, matches_cached
	input  wire logic [zbh_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output int                                      mismatches,
	output int                                      pending
);

	localparam int KINDS       = zbh_pkg::PIECE_KINDS_DEF;
	localparam int SQUARES     = zbh_pkg::SQUARE_COUNT_DEF;
	localparam int MOVES       = zbh_pkg::MOVE_KEY_COUNT_DEF;
	localparam int FROZEN_AT   = KINDS * SQUARES * 2;
	localparam int MOVE_AT     = FROZEN_AT + 2 * SQUARES;
	localparam int SIDE_AT     = MOVE_AT + MOVES;
	localparam int TABLE_DEPTH = SIDE_AT + 1;

	typedef struct packed {
		logic [5:0]  pad;
		logic [31:0] cached;
		logic [15:0] move;
		logic [6:0]  frz_black;
		logic [6:0]  frz_white;
		logic        black_to_move;
		logic        black;
		logic [2:0]  kind;
		logic        occupied;
		logic [5:0]  square;
	} square_beat_t;

	typedef struct packed {
		logic [31:0] hash;
		logic        hit;
	} board_result_t;

	logic [zbh_pkg::SEED_W-1:0] seed_reg;
	logic                       keys_built;
	logic [31:0]                board_acc;
	logic [31:0]                key_table [0:TABLE_DEPTH-1];
	board_result_t              expected_hashes [$];

	function automatic void fill_key_table(input logic [zbh_pkg::SEED_W-1:0] seed);
		logic [zbh_pkg::SEED_W-1:0] lcg;
		lcg = seed ^ zbh_pkg::LCG_MULT;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			lcg = lcg * zbh_pkg::LCG_MULT + zbh_pkg::LCG_ADD;
			key_table[i] = lcg[47:16];
		end
	endfunction

	// anything outside 0..SQUARES-1, the -1 marker included, adds nothing
	function automatic logic [31:0] frozen_term(input logic [6:0] code, input int colour);
		int sq;
		sq = int'($signed(code));
		if (sq < 0 || sq >= SQUARES)
			return '0;
		return key_table[FROZEN_AT + 2 * sq + colour];
	endfunction

	task automatic note(input string what, input logic [31:0] want, input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected %h, got %h", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		square_beat_t  beat;
		board_result_t want;
		logic [31:0]   folded;
		if (!arst_n) begin
			seed_reg   = zbh_pkg::SEED_RESET;
			keys_built = 1'b0;
			board_acc  = '0;
			expected_hashes.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			// the seed only counts until the table has been built
			if (cfg_valid && cfg_ready && !keys_built)
				seed_reg = cfg_data;

			if (m_tvalid && m_tready) begin
				if (expected_hashes.size() == 0) begin
					note("result beat with no board waiting", '0, m_tdata[31:0]);
				end else begin
					want = expected_hashes.pop_front();
					if (m_tdata[31:0] != want.hash)
						note("hash", want.hash, m_tdata[31:0]);
					if (m_tdata[32] != want.hit)
						note("matches_cached", 32'(want.hit), 32'(m_tdata[32]));
				end
			end

			if (s_tvalid && s_tready) begin
				beat = s_tdata;
				if (!keys_built) begin
					fill_key_table(seed_reg);
					keys_built = 1'b1;
				end
				if (beat.occupied && beat.kind < KINDS && beat.square < SQUARES)
					board_acc ^= key_table[(beat.kind * SQUARES + beat.square) * 2 + beat.black];
				if (s_tlast) begin
					folded = board_acc;
					if (beat.black_to_move)
						folded ^= key_table[SIDE_AT];
					folded ^= frozen_term(beat.frz_white, 0);
					folded ^= frozen_term(beat.frz_black, 1);
					folded ^= key_table[MOVE_AT + (beat.move % MOVES)];
					want.hash = folded;
					want.hit  = (folded == beat.cached);
					expected_hashes.push_back(want);
					board_acc = '0;
				end
			end

			pending = expected_hashes.size();
		end
	end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: top level bench for zobrist_board_hash
// Streams directed and random boards under three idling mixes, sets the seed
// before the first beat and again later, and lets the checker judge results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	// margin for a result to show after a last beat
	localparam int SETTLE      = 8;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_BEATS = 434;

	// frozen square codes
	localparam logic [6:0] FROZEN_NONE = 7'h7F;
	localparam logic [6:0] FROZEN_MIN  = 7'h40;

	logic                               clk;
	logic                               arst_n;
	logic                               s_tvalid;
	logic                               s_tready;
	// from bit 0: square, occupied, piece_type, piece_black, black_to_move,
	// frozen_white_square, frozen_black_square, move_count, stored_hash
	logic [zbh_pkg::IN_TDATA_W-1:0]     s_tdata;
	logic                               s_tlast;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [zbh_pkg::SEED_W-1:0]         cfg_data;
	logic                               m_tvalid;
	logic                               m_tready;
	// from bit 0: hash, matches_cached
	logic [zbh_pkg::OUT_TDATA_W-1:0]    m_tdata;

	int                                 mismatches;
	int                                 pending;
	int                                 tx_idle;
	int                                 rx_idle;
	int                                 cycle_count;
	logic [31:0]                        seen_hash;
	logic [zbh_pkg::IN_TDATA_W-1:0]     board [$];

	zobrist_board_hash dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	board_hash_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: stall at random, change only on the falling edge
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle);
	end

	// remember the last hash delivered so that a board can be replayed to match
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			seen_hash <= m_tdata[31:0];
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("zobrist_board_hash: mismatch");
			$finish;
		end
	end

	function automatic logic [zbh_pkg::IN_TDATA_W-1:0] pack_square(
		input logic [5:0]  sq,
		input logic        occ,
		input logic [2:0]  kind,
		input logic        blk,
		input logic        btm,
		input logic [6:0]  fw,
		input logic [6:0]  fb,
		input logic [15:0] mv,
		input logic [31:0] cached
	);
		return {6'd0, cached, mv, fb, fw, btm, blk, kind, occ, sq};
	endfunction

	// mostly none or a real square, now and then any 7-bit code
	function automatic logic [6:0] pick_frozen();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return FROZEN_NONE;
		if (r < 9)
			return 7'($urandom_range(0, 63));
		return 7'($urandom);
	endfunction

	function automatic logic [31:0] pick_cached();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	// hold valid until the beat is taken; idle first at the current rate
	task automatic put_beat(input logic [zbh_pkg::IN_TDATA_W-1:0] data, input logic lst);
		while ($urandom_range(0, 99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_board(inout int sent);
		for (int i = 0; i < board.size(); i++)
			put_beat(board[i], i == board.size() - 1);
		sent += board.size();
	endtask

	// drop valid and wait until every board has delivered its hash
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_seed(input logic [zbh_pkg::SEED_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// resend the last board with the hash it produced as the cached value
	task automatic replay_matching(inout int sent);
		drain();
		board[board.size() - 1][73:42] = seen_hash;
		send_board(sent);
	endtask

	task automatic random_board();
		int n;
		n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
		board.delete();
		for (int i = 0; i < n; i++) begin
			board.push_back(pack_square(
				6'($urandom),
				$urandom_range(0, 3) != 0,
				($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6)),
				1'($urandom),
				1'($urandom),
				pick_frozen(),
				pick_frozen(),
				16'($urandom),
				pick_cached()));
		end
	endtask

	task automatic directed_boards(inout int sent);
		// single beat, lowest values everywhere, no frozen squares
		board.delete();
		board.push_back(pack_square(6'd0, 1'b1, 3'd0, 1'b0, 1'b0,
			FROZEN_NONE, FROZEN_NONE, 16'd0, 32'h0));
		send_board(sent);

		// top square and kind, a kind out of range, an empty square with
		// junk fields, the same piece twice so that it cancels, highest moves
		board.delete();
		board.push_back(pack_square(6'd63, 1'b1, 3'd6, 1'b1, 1'b0,
			7'd5, 7'd9, 16'hFFFF, 32'h1234_5678));
		board.push_back(pack_square(6'd10, 1'b1, 3'd7, 1'b1, 1'b1,
			FROZEN_NONE, FROZEN_NONE, 16'd0, 32'h0));
		board.push_back(pack_square(6'd5, 1'b0, 3'd3, 1'b1, 1'b1,
			7'd1, 7'd2, 16'd3, 32'h0));
		board.push_back(pack_square(6'd63, 1'b1, 3'd6, 1'b1, 1'b1,
			7'd63, 7'd0, 16'hFFFF, 32'hFFFF_FFFF));
		send_board(sent);

		// the same board again, now expecting the cached hash to match
		replay_matching(sent);

		// most negative frozen codes, move count wrapping to zero
		board.delete();
		board.push_back(pack_square(6'd33, 1'b0, 3'd7, 1'b1, 1'b0,
			FROZEN_MIN, 7'h41, 16'd200, 32'h0));
		send_board(sent);

		board.delete();
		board.push_back(pack_square(6'd0, 1'b1, 3'd0, 1'b1, 1'b1,
			FROZEN_NONE, FROZEN_NONE, 16'd0, 32'h0));
		board.push_back(pack_square(6'd1, 1'b1, 3'd5, 1'b0, 1'b0,
			7'd0, 7'd63, 16'd199, 32'h5555_5555));
		send_board(sent);

		// both frozen pieces on one square
		board.delete();
		board.push_back(pack_square(6'd32, 1'b1, 3'd2, 1'b0, 1'b1,
			7'd32, 7'd32, 16'd1, 32'hAAAA_AAAA));
		send_board(sent);
	endtask

	initial begin : stimulus
		int sent;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		m_tready    = 1'b0;
		tx_idle     = 23;
		rx_idle     = 61;
		cycle_count = 0;
		seen_hash   = '0;
		arst_n      = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// seed writes before the first beat each refill; the last one stands
		write_seed('1);
		write_seed('0);
		case ($urandom_range(0, 2))
			0:       write_seed('1);
			1:       write_seed('0);
			default: write_seed(zbh_pkg::SEED_W'({$urandom, $urandom}));
		endcase

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle = (phase == 0) ? 23 : (phase == 1) ? 61 : 0;
			rx_idle = (phase == 0) ? 61 : (phase == 1) ? 23 : 0;
			sent = 0;
			if (phase == 0) begin
				directed_boards(sent);
			end else begin
				// let the pipe empty, then write a seed that must not take hold
				drain();
				repeat (SETTLE) @(negedge clk);
				write_seed((phase == 1) ? '0 : '1);
			end
			while (sent < PHASE_BEATS) begin
				random_board();
				send_board(sent);
				if ($urandom_range(0, 5) == 0)
					replay_matching(sent);
			end
		end

		drain();
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("zobrist_board_hash: match");
		end else begin
			$display("zobrist_board_hash: mismatch");
		end
		$finish;
	end

endmodule
